// File: hw/rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants for the tangent frame pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int COMP_W     = 16;  // Q1.15 component
  localparam int CAND_W     = 17;  // candidate tangent component (negated input)
  localparam int CROSS_W    = 33;  // difference of two 16x16 products
  localparam int MAG_W      = 16;  // normalised magnitude, at most 2^15
  localparam int L2_W       = 32;  // squared length of normalised vector
  localparam int ROOT_W     = 31;  // floor(sqrt(L2 * 2^30))
  localparam int REM_W      = 33;  // square root partial remainder
  localparam int SQRT_STEPS = 31;  // one root bit per step
  localparam int Q_W        = 16;  // quotient bits below the overflow check
  localparam int NORM_LO    = 14;  // largest magnitude lands in [2^14, 2^15]

  localparam logic [MAG_W-1:0] MAG_TOP = 16'h8000;
  localparam logic [Q_W-1:0]   Q_POS_MAX = 16'h7FFF;
  localparam logic [Q_W-1:0]   Q_NEG_MAX = 16'h8000;

  typedef logic signed [COMP_W-1:0] comp_t;

  localparam comp_t COMP_MAX = 16'sh7FFF;
  localparam comp_t COMP_MIN = -16'sh8000;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

  // normal and flag riding alongside the first normaliser
  typedef struct packed {
    vec_t n;
    logic last;
  } nrm_sb_t;

  // tangent and flag riding alongside the second normaliser
  typedef struct packed {
    vec_t t;
    logic last;
  } tan_sb_t;

  typedef struct packed {
    vec_t t;
    vec_t b;
    logic last;
  } out_item_t;

endpackage

// File: hw/rtl/tfn_cand.sv
// ----------------------------------------------------------------------------
// tfn_cand
// Picks the longer of the two candidate tangents; one register stage.
// ----------------------------------------------------------------------------
module tfn_cand (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  tfn_pkg::nrm_sb_t                    in_sb,
  output logic                                out_valid,
  output logic signed [tfn_pkg::CAND_W-1:0]   out_x,
  output logic signed [tfn_pkg::CAND_W-1:0]   out_y,
  output logic signed [tfn_pkg::CAND_W-1:0]   out_z,
  output tfn_pkg::nrm_sb_t                    out_sb
);
  import tfn_pkg::*;

  logic signed [CAND_W-1:0] nx_c, ny_c, nz_c;
  logic [CAND_W-1:0]        ay_c, az_c;
  logic                     valid_r;
  logic signed [CAND_W-1:0] x_r, y_r, z_r;
  nrm_sb_t                  sb_r;

  assign nx_c = CAND_W'(in_sb.n.x);
  assign ny_c = CAND_W'(in_sb.n.y);
  assign nz_c = CAND_W'(in_sb.n.z);
  // ny^2 > nz^2 is the same test as |ny| > |nz|
  assign ay_c = ny_c[CAND_W-1] ? CAND_W'(-ny_c) : CAND_W'(ny_c);
  assign az_c = nz_c[CAND_W-1] ? CAND_W'(-nz_c) : CAND_W'(nz_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r <= in_sb;
      if (ay_c > az_c) begin
        x_r <= ny_c;
        y_r <= -nx_c;
        z_r <= '0;
      end else begin
        x_r <= -nz_c;
        y_r <= '0;
        z_r <= nx_c;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_sb    = sb_r;

endmodule

// File: hw/rtl/tfn_unit_vec.sv
// ----------------------------------------------------------------------------
// tfn_unit_vec
// Pipelined fixed point normaliser: range scaling, squared length, staged
// square root and three staged restoring dividers, then saturation.
// ----------------------------------------------------------------------------
module tfn_unit_vec #(
  parameter int IW        = 17,
  parameter int FRAC_BITS = 15,
  parameter int SBW       = 49
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] in_x,
  input  logic signed [IW-1:0] in_y,
  input  logic signed [IW-1:0] in_z,
  input  logic [SBW-1:0]       in_sb,
  output logic                 out_valid,
  output tfn_pkg::vec_t        out_vec,
  output logic [SBW-1:0]       out_sb
);
  import tfn_pkg::*;

  localparam int PW    = $clog2(IW);
  localparam int NW    = FRAC_BITS + 31;
  localparam int EW    = (NW > ROOT_W + Q_W) ? NW : ROOT_W + Q_W;
  localparam int DEPTH = 6 + SQRT_STEPS + 1 + Q_W + 1;

  // stage 1: sign and magnitude, largest magnitude
  logic signed [IW-1:0] in_c [3];
  logic [IW-1:0]        abs_c [3];
  logic [IW-1:0]        max_c;
  logic [IW-1:0]        a_mag_r [3];
  logic [2:0]           a_neg_r;
  logic [IW-1:0]        a_m_r;

  // stage 2: leading one
  logic [PW-1:0]        p_c;
  logic [IW-1:0]        b_mag_r [3];
  logic [IW-1:0]        b_m_r;
  logic [2:0]           b_neg_r;
  logic [PW-1:0]        b_p_r;
  logic                 b_zero_r;

  // stage 3: coarse shift
  logic [MAG_W-1:0]     sh_c [3];
  logic [MAG_W-1:0]     msh_c;
  logic [MAG_W-1:0]     c_mag_r [3];
  logic [MAG_W-1:0]     c_m_r;
  logic                 c_big_r;
  logic [2:0]           c_neg_r;
  logic                 c_zero_r;

  // stage 4: final one-bit trim
  logic [MAG_W-1:0]     d_mag_r [3];
  logic [2:0]           d_neg_r;
  logic                 d_zero_r;

  // stage 5: squares
  logic [L2_W-1:0]      sq_c [3];
  logic [L2_W-1:0]      e_sq_r [3];
  logic [MAG_W-1:0]     e_mag_r [3];
  logic [2:0]           e_neg_r;
  logic                 e_zero_r;

  // stage 6: squared length
  logic [L2_W-1:0]      f_l2_r;
  logic [MAG_W-1:0]     f_mag_r [3];
  logic [2:0]           f_neg_r;
  logic                 f_zero_r;

  // square root steps
  logic [REM_W-1:0]     r_rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0]    r_root_r [SQRT_STEPS];
  logic [L2_W-1:0]      r_l2_r   [SQRT_STEPS];
  logic [MAG_W-1:0]     r_mag_r  [SQRT_STEPS][3];
  logic [2:0]           r_neg_r  [SQRT_STEPS];
  logic                 r_zero_r [SQRT_STEPS];

  // divider set-up
  logic [ROOT_W-1:0]    s_c;
  logic [NW-1:0]        n_c [3];
  logic [2:0]           ovf_c;
  logic [NW-1:0]        v_n_r [3];
  logic [2:0]           v_ovf_r;
  logic [ROOT_W-1:0]    v_s_r;
  logic [2:0]           v_neg_r;
  logic                 v_zero_r;

  // divider steps
  logic [NW-1:0]        q_rem_r  [Q_W][3];
  logic [Q_W-1:0]       q_q_r    [Q_W][3];
  logic [2:0]           q_ovf_r  [Q_W];
  logic [ROOT_W-1:0]    q_s_r    [Q_W];
  logic [2:0]           q_neg_r  [Q_W];
  logic                 q_zero_r [Q_W];

  // output
  comp_t                res_c [3];
  vec_t                 out_r;
  logic [DEPTH-1:0]     vld_r;
  logic [SBW-1:0]       sb_r [DEPTH];

  // ---------------- stage 1
  assign in_c[0] = in_x;
  assign in_c[1] = in_y;
  assign in_c[2] = in_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      abs_c[k] = in_c[k][IW-1] ? IW'(-in_c[k]) : IW'(in_c[k]);
    end
    max_c = abs_c[0];
    if (abs_c[1] > max_c) max_c = abs_c[1];
    if (abs_c[2] > max_c) max_c = abs_c[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_mag_r[k] <= abs_c[k];
        a_neg_r[k] <= in_c[k][IW-1];
      end
      a_m_r <= max_c;
    end
  end

  // ---------------- stage 2
  always_comb begin
    p_c = '0;
    for (int b = 0; b < IW; b++) begin
      if (a_m_r[b]) p_c = PW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mag_r  <= a_mag_r;
      b_m_r    <= a_m_r;
      b_neg_r  <= a_neg_r;
      b_p_r    <= p_c;
      b_zero_r <= (a_m_r == '0);
    end
  end

  // ---------------- stage 3: bring the top bit to bit 14, or to bit 15 for big values
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (b_p_r < PW'(NORM_LO)) begin
        sh_c[k] = MAG_W'(b_mag_r[k] << (PW'(NORM_LO) - b_p_r));
      end else if (b_p_r > PW'(NORM_LO)) begin
        sh_c[k] = MAG_W'(b_mag_r[k] >> (b_p_r - PW'(NORM_LO + 1)));
      end else begin
        sh_c[k] = MAG_W'(b_mag_r[k]);
      end
    end
    if (b_p_r > PW'(NORM_LO)) begin
      msh_c = MAG_W'(b_m_r >> (b_p_r - PW'(NORM_LO + 1)));
    end else begin
      msh_c = MAG_W'(b_m_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_mag_r  <= sh_c;
      c_m_r    <= msh_c;
      c_big_r  <= (b_p_r > PW'(NORM_LO));
      c_neg_r  <= b_neg_r;
      c_zero_r <= b_zero_r;
    end
  end

  // ---------------- stage 4: exactly 2^15 may stay, anything above goes one more
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_mag_r[k] <= (c_big_r && c_m_r != MAG_TOP) ? (c_mag_r[k] >> 1) : c_mag_r[k];
      end
      d_neg_r  <= c_neg_r;
      d_zero_r <= c_zero_r;
    end
  end

  // ---------------- stage 5
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_c[k] = L2_W'(d_mag_r[k]) * L2_W'(d_mag_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_sq_r   <= sq_c;
      e_mag_r  <= d_mag_r;
      e_neg_r  <= d_neg_r;
      e_zero_r <= d_zero_r;
    end
  end

  // ---------------- stage 6
  always_ff @(posedge clk) begin
    if (en) begin
      f_l2_r   <= e_sq_r[0] + e_sq_r[1] + e_sq_r[2];
      f_mag_r  <= e_mag_r;
      f_neg_r  <= e_neg_r;
      f_zero_r <= e_zero_r;
    end
  end

  // ---------------- square root of L2 * 2^30, two radicand bits per step
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [L2_W-1:0]   l2_i;
    logic [MAG_W-1:0]  mag_i [3];
    logic [2:0]        neg_i;
    logic              zero_i;
    logic [REM_W+1:0]  t_c;
    logic [REM_W+1:0]  tr_c;

    if (i == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign l2_i   = f_l2_r;
      assign mag_i  = f_mag_r;
      assign neg_i  = f_neg_r;
      assign zero_i = f_zero_r;
    end else begin : g_next
      assign rem_i  = r_rem_r[i-1];
      assign root_i = r_root_r[i-1];
      assign l2_i   = r_l2_r[i-1];
      assign mag_i  = r_mag_r[i-1];
      assign neg_i  = r_neg_r[i-1];
      assign zero_i = r_zero_r[i-1];
    end

    // radicand bits run out after the length word; the rest are zeros
    assign t_c  = {rem_i, l2_i[L2_W-1 -: 2]};
    assign tr_c = {2'b00, root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (t_c >= tr_c) begin
          r_rem_r[i]  <= REM_W'(t_c - tr_c);
          r_root_r[i] <= {root_i[ROOT_W-2:0], 1'b1};
        end else begin
          r_rem_r[i]  <= REM_W'(t_c);
          r_root_r[i] <= {root_i[ROOT_W-2:0], 1'b0};
        end
        r_l2_r[i]   <= l2_i << 2;
        r_mag_r[i]  <= mag_i;
        r_neg_r[i]  <= neg_i;
        r_zero_r[i] <= zero_i;
      end
    end
  end

  // ---------------- divider set-up: rounded numerator, overflow at 2^16 and above
  assign s_c = r_root_r[SQRT_STEPS-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_c[k]   = (NW'(r_mag_r[SQRT_STEPS-1][k]) << (FRAC_BITS + 15)) + NW'(s_c >> 1);
      ovf_c[k] = EW'(n_c[k]) >= (EW'(s_c) << Q_W);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_n_r    <= n_c;
      v_ovf_r  <= ovf_c;
      v_s_r    <= s_c;
      v_neg_r  <= r_neg_r[SQRT_STEPS-1];
      v_zero_r <= r_zero_r[SQRT_STEPS-1];
    end
  end

  // ---------------- restoring division, one quotient bit per step
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic [NW-1:0]     rem_i [3];
    logic [Q_W-1:0]    q_i   [3];
    logic [2:0]        ovf_i;
    logic [ROOT_W-1:0] s_i;
    logic [2:0]        neg_i;
    logic              zero_i;
    logic [EW-1:0]     ds_c;
    logic [NW-1:0]     rem_nxt [3];
    logic [Q_W-1:0]    q_nxt   [3];

    if (j == 0) begin : g_first
      assign rem_i  = v_n_r;
      assign q_i    = '{default: '0};
      assign ovf_i  = v_ovf_r;
      assign s_i    = v_s_r;
      assign neg_i  = v_neg_r;
      assign zero_i = v_zero_r;
    end else begin : g_next
      assign rem_i  = q_rem_r[j-1];
      assign q_i    = q_q_r[j-1];
      assign ovf_i  = q_ovf_r[j-1];
      assign s_i    = q_s_r[j-1];
      assign neg_i  = q_neg_r[j-1];
      assign zero_i = q_zero_r[j-1];
    end

    assign ds_c = EW'(s_i) << (Q_W - 1 - j);

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem_nxt[l] = rem_i[l];
        q_nxt[l]   = q_i[l];
        if (EW'(rem_i[l]) >= ds_c) begin
          rem_nxt[l]            = NW'(EW'(rem_i[l]) - ds_c);
          q_nxt[l][Q_W - 1 - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_rem_r[j]  <= rem_nxt;
        q_q_r[j]    <= q_nxt;
        q_ovf_r[j]  <= ovf_i;
        q_s_r[j]    <= s_i;
        q_neg_r[j]  <= neg_i;
        q_zero_r[j] <= zero_i;
      end
    end
  end

  // ---------------- sign restore and saturation
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (q_zero_r[Q_W-1]) begin
        res_c[l] = '0;
      end else if (q_neg_r[Q_W-1][l]) begin
        if (q_ovf_r[Q_W-1][l] || q_q_r[Q_W-1][l] > Q_NEG_MAX) res_c[l] = COMP_MIN;
        else res_c[l] = comp_t'(-q_q_r[Q_W-1][l]);
      end else begin
        if (q_ovf_r[Q_W-1][l] || q_q_r[Q_W-1][l] > Q_POS_MAX) res_c[l] = COMP_MAX;
        else res_c[l] = comp_t'(q_q_r[Q_W-1][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.x <= res_c[0];
      out_r.y <= res_c[1];
      out_r.z <= res_c[2];
    end
  end

  // ---------------- valid and side data travel with the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= in_sb;
      for (int d = 1; d < DEPTH; d++) begin
        sb_r[d] <= sb_r[d-1];
      end
    end
  end

  assign out_valid = vld_r[DEPTH-1];
  assign out_vec   = out_r;
  assign out_sb    = sb_r[DEPTH-1];

endmodule

// File: hw/rtl/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross
// Cross product of the unit tangent with the normal: products, then sums.
// ----------------------------------------------------------------------------
module tfn_cross (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  tfn_pkg::vec_t                        in_t,
  input  tfn_pkg::nrm_sb_t                     in_sb,
  output logic                                 out_valid,
  output logic signed [tfn_pkg::CROSS_W-1:0]   out_x,
  output logic signed [tfn_pkg::CROSS_W-1:0]   out_y,
  output logic signed [tfn_pkg::CROSS_W-1:0]   out_z,
  output tfn_pkg::tan_sb_t                     out_sb
);
  import tfn_pkg::*;

  localparam int PROD_W = 2 * COMP_W;

  logic [1:0]               vld_r;
  logic signed [PROD_W-1:0] p_r [6];
  tan_sb_t                  m_sb_r;
  tan_sb_t                  s_sb_r;
  logic signed [CROSS_W-1:0] x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= PROD_W'(in_t.y) * PROD_W'(in_sb.n.z);
      p_r[1] <= PROD_W'(in_t.z) * PROD_W'(in_sb.n.y);
      p_r[2] <= PROD_W'(in_t.z) * PROD_W'(in_sb.n.x);
      p_r[3] <= PROD_W'(in_t.x) * PROD_W'(in_sb.n.z);
      p_r[4] <= PROD_W'(in_t.x) * PROD_W'(in_sb.n.y);
      p_r[5] <= PROD_W'(in_t.y) * PROD_W'(in_sb.n.x);
      m_sb_r.t    <= in_t;
      m_sb_r.last <= in_sb.last;

      x_r    <= CROSS_W'(p_r[0]) - CROSS_W'(p_r[1]);
      y_r    <= CROSS_W'(p_r[2]) - CROSS_W'(p_r[3]);
      z_r    <= CROSS_W'(p_r[4]) - CROSS_W'(p_r[5]);
      s_sb_r <= m_sb_r;
    end
  end

  assign out_valid = vld_r[1];
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_sb    = s_sb_r;

endmodule

// File: hw/rtl/tangent_frame_from_normal.sv
// ----------------------------------------------------------------------------
// tangent_frame_from_normal
// Unit tangent and binormal from one Q1.15 vertex normal per item.
// ----------------------------------------------------------------------------
//  Channel | Direction | Ports                                   | Handshake
//  in      | input     | in_normal_x/y/z, in_last_vertex         | in_valid/in_ready
//  out     | output    | out_tangent_x/y/z, out_binormal_x/y/z,  | out_valid/out_ready
//          |           | out_last_out                            |
//
//  One item per clock sustained while the skid register is empty. An accepted item
//  passes candidate select, tangent normaliser, cross product, binormal
//  normaliser and output register, in that order.
//  Most of each normaliser's stages are its square root, 31 stages of one root
//  bit, and its dividers, 16 stages of one quotient bit.
//  Reset clears the valid bits only; the data stages need no reset.
//  A stalled output parks one item in a skid register; the whole pipeline then
//  freezes until it drains, so nothing is dropped or duplicated.
// ----------------------------------------------------------------------------
module tangent_frame_from_normal #(
  parameter int FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic               in_last_vertex,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_tangent_x,
  output logic signed [15:0] out_tangent_y,
  output logic signed [15:0] out_tangent_z,
  output logic signed [15:0] out_binormal_x,
  output logic signed [15:0] out_binormal_y,
  output logic signed [15:0] out_binormal_z,
  output logic               out_last_out
);
  import tfn_pkg::*;

  logic                      en;
  nrm_sb_t                   in_sb;

  logic                      cand_valid;
  logic signed [CAND_W-1:0]  cand_x, cand_y, cand_z;
  nrm_sb_t                   cand_sb;

  logic                      u1_valid;
  vec_t                      u1_vec;
  logic [$bits(nrm_sb_t)-1:0] u1_sb_bits;
  nrm_sb_t                   u1_sb;

  logic                      cr_valid;
  logic signed [CROSS_W-1:0] cr_x, cr_y, cr_z;
  tan_sb_t                   cr_sb;

  logic                      u2_valid;
  vec_t                      u2_vec;
  logic [$bits(tan_sb_t)-1:0] u2_sb_bits;
  tan_sb_t                   u2_sb;

  out_item_t                 item_c;
  out_item_t                 out_item_r;
  out_item_t                 skid_r;
  logic                      out_valid_r;
  logic                      skid_full_r;
  logic                      push;

  // the pipeline runs whenever the skid register is free
  assign en       = ~skid_full_r;
  assign in_ready = en;

  assign in_sb.n.x  = in_normal_x;
  assign in_sb.n.y  = in_normal_y;
  assign in_sb.n.z  = in_normal_z;
  assign in_sb.last = in_last_vertex;

  tfn_cand u_cand (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_sb     (in_sb),
    .out_valid (cand_valid),
    .out_x     (cand_x),
    .out_y     (cand_y),
    .out_z     (cand_z),
    .out_sb    (cand_sb)
  );

  // tangent: normalise the chosen candidate
  tfn_unit_vec #(
    .IW        (CAND_W),
    .FRAC_BITS (FRAC_BITS),
    .SBW       ($bits(nrm_sb_t))
  ) u_norm_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cand_valid),
    .in_x      (cand_x),
    .in_y      (cand_y),
    .in_z      (cand_z),
    .in_sb     (cand_sb),
    .out_valid (u1_valid),
    .out_vec   (u1_vec),
    .out_sb    (u1_sb_bits)
  );

  assign u1_sb = nrm_sb_t'(u1_sb_bits);

  // saturated tangent x normal
  tfn_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (u1_valid),
    .in_t      (u1_vec),
    .in_sb     (u1_sb),
    .out_valid (cr_valid),
    .out_x     (cr_x),
    .out_y     (cr_y),
    .out_z     (cr_z),
    .out_sb    (cr_sb)
  );

  // binormal: normalise the cross product
  tfn_unit_vec #(
    .IW        (CROSS_W),
    .FRAC_BITS (FRAC_BITS),
    .SBW       ($bits(tan_sb_t))
  ) u_norm_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cr_valid),
    .in_x      (cr_x),
    .in_y      (cr_y),
    .in_z      (cr_z),
    .in_sb     (cr_sb),
    .out_valid (u2_valid),
    .out_vec   (u2_vec),
    .out_sb    (u2_sb_bits)
  );

  assign u2_sb = tan_sb_t'(u2_sb_bits);

  assign item_c.t    = u2_sb.t;
  assign item_c.b    = u2_vec;
  assign item_c.last = u2_sb.last;

  // an item leaves the pipeline on every enabled cycle with a valid last stage
  assign push = en & u2_valid;

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_ready) skid_full_r <= 1'b0;
    end else if (push) begin
      if (out_valid_r && !out_ready) skid_full_r <= 1'b1;
      else out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_ready) out_item_r <= skid_r;
    end else if (push) begin
      if (out_valid_r && !out_ready) skid_r <= item_c;
      else out_item_r <= item_c;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tangent_x  = out_item_r.t.x;
  assign out_tangent_y  = out_item_r.t.y;
  assign out_tangent_z  = out_item_r.t.z;
  assign out_binormal_x = out_item_r.b.x;
  assign out_binormal_y = out_item_r.b.y;
  assign out_binormal_z = out_item_r.b.z;
  assign out_last_out   = out_item_r.last;

  // skid entry only ever fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid entry full with no item in the output register");

  // a push into a blocked output must park in the skid entry
  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_ready) |=> skid_full_r)
    else $error("item pushed into blocked output was not parked");

  // draining the skid entry keeps an item on the output
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_full_r && out_ready) |=> (!skid_full_r && out_valid_r))
    else $error("skid entry did not drain into the output register");

endmodule

// File: tb/sv/tangent_frame_from_normal_tb.sv
// ----------------------------------------------------------------------------
// tangent_frame_from_normal_tb
// Streams vertex normals through the tangent frame pipeline and checks every
// tangent and binormal against a bit-exact fixed point predictor.
// ----------------------------------------------------------------------------
module tangent_frame_from_normal_tb;
  import tfn_pkg::*;

  localparam int FRAC = 15;
  localparam int LATENCY = 114;

  typedef struct {
    comp_t tx, ty, tz, bx, by, bz;
    logic  last;
  } frame_t;

  // integer square root, floor
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // normalise a vector, block-shifted magnitudes, rounded divide, saturate
  function automatic void unit_vector(input longint v[3], output longint r[3]);
    longint unsigned mag[3];
    bit neg[3];
    longint unsigned m, l2, s, q;
    m = 0;
    l2 = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      r = '{0, 0, 0};
      return;
    end
    while (m < (64'd1 << 14)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    while (m > (64'd1 << 15)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    for (int i = 0; i < 3; i++) l2 += mag[i] * mag[i];
    s = isqrt(l2 << 30);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << (FRAC + 15)) + (s >> 1)) / s;
      if (neg[i]) r[i] = q > 32768 ? -32768 : -longint'(q);
      else        r[i] = q > 32767 ? 32767 : longint'(q);
    end
  endfunction

  function automatic frame_t predict_frame(comp_t nx, comp_t ny, comp_t nz, logic last);
    longint cand[3], t[3], c[3], b[3];
    longint x, y, z;
    frame_t f;
    x = longint'(nx);
    y = longint'(ny);
    z = longint'(nz);
    // strictly longer first candidate only when ny^2 > nz^2
    if (y * y > z * z) cand = '{y, -x, 0};
    else               cand = '{-z, 0, x};
    unit_vector(cand, t);
    c[0] = t[1] * z - t[2] * y;
    c[1] = t[2] * x - t[0] * z;
    c[2] = t[0] * y - t[1] * x;
    unit_vector(c, b);
    f.tx = comp_t'(t[0]); f.ty = comp_t'(t[1]); f.tz = comp_t'(t[2]);
    f.bx = comp_t'(b[0]); f.by = comp_t'(b[1]); f.bz = comp_t'(b[2]);
    f.last = last;
    return f;
  endfunction

  class frame_scoreboard;
    frame_t pending[$];
    int errors = 0;

    function void note_normal(comp_t nx, comp_t ny, comp_t nz, logic last);
      pending.push_back(predict_frame(nx, ny, nz, last));
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_frame(frame_t got);
      frame_t e;
      if (pending.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("tangent_x", e.tx, got.tx);
      cmp("tangent_y", e.ty, got.ty);
      cmp("tangent_z", e.tz, got.tz);
      cmp("binormal_x", e.bx, got.bx);
      cmp("binormal_y", e.by, got.by);
      cmp("binormal_z", e.bz, got.bz);
      cmp("last_out", e.last, got.last);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [15:0] in_normal_x = 0, in_normal_y = 0, in_normal_z = 0;
  logic in_last_vertex = 0;
  logic signed [15:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic signed [15:0] out_binormal_x, out_binormal_y, out_binormal_z;
  logic out_last_out;

  frame_scoreboard frames = new();
  bit hold_off = 0;      // long receiver stall, set by the stimulus
  bit hold_done = 0;

  tangent_frame_from_normal #(.FRAC_BITS(FRAC)) u_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // fixed ceiling on the whole run
  initial begin
    #4000000;
    $display("** tangent_frame_from_normal: FAILED **");
    $finish;
  end

  // send one normal; valid held until accepted, no drop between back-to-back items
  task automatic send_normal(comp_t nx, comp_t ny, comp_t nz, logic last);
    in_valid       <= 1'b1;
    in_normal_x    <= nx;
    in_normal_y    <= ny;
    in_normal_z    <= nz;
    in_last_vertex <= last;
    do @(posedge clk); while (!in_ready);
    frames.note_normal(nx, ny, nz, last);
  endtask

  task automatic idle_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'(int'($urandom_range(0, 3)) - 2);       // near zero
      1: return $urandom_range(0, 1) ? COMP_MAX : COMP_MIN;
      2: return comp_t'(int'($urandom_range(0, 255)) - 128);   // small, deep shift
      default: return comp_t'($urandom);
    endcase
  endfunction

  // receiver: own stall pattern, plus a long hold-off when asked
  initial begin
    int phase;
    phase = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1;
        hold_off = 0;
      end
      phase++;
      case ((phase / 200) % 3)
        0: out_ready <= 1'b1;                          // no stalls
        1: out_ready <= (phase % 7) != 3;              // periodic
        default: out_ready <= $urandom_range(0, 3) != 0;
      endcase
    end
  end

  // result monitor, sampled at the edge
  always @(posedge clk) begin
    frame_t got;
    if (rst_n && out_valid && out_ready) begin
      got.tx = out_tangent_x; got.ty = out_tangent_y; got.tz = out_tangent_z;
      got.bx = out_binormal_x; got.by = out_binormal_y; got.bz = out_binormal_z;
      got.last = out_last_out;
      frames.check_frame(got);
    end
  end

  initial begin
    int guard;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, tie between candidates, zero normal, axes
    send_normal(0, 0, 0, 0);
    send_normal(COMP_MAX, 0, 0, 1);
    send_normal(COMP_MIN, 0, 0, 0);
    send_normal(0, COMP_MAX, 0, 0);
    send_normal(0, COMP_MIN, 0, 1);
    send_normal(0, 0, COMP_MAX, 0);
    send_normal(0, 0, COMP_MIN, 0);
    send_normal(COMP_MIN, COMP_MIN, COMP_MIN, 1);
    send_normal(COMP_MAX, COMP_MAX, COMP_MAX, 0);
    send_normal(100, 5000, -5000, 0);                  // |ny| == |nz|, second kept
    send_normal(100, 5001, -5000, 0);                  // first just longer
    send_normal(COMP_MIN, COMP_MAX, COMP_MIN, 0);
    send_normal(1, 1, 0, 0);
    send_normal(-1, 0, 1, 1);
    send_normal(0, 1, 0, 0);
    send_normal(23170, 23170, 0, 0);
    send_normal(-18919, 18919, 18918, 1);
    send_normal(16'sh5555, -16'sh2AAA, 16'sh0FFF, 0);

    // sender pauses until everything has drained
    idle_input(1);
    while (frames.pending.size() != 0) @(posedge clk);

    for (int k = 0; k < 1750; k++) begin
      if (k == 600) hold_off = 1;      // block fills, input stalls
      send_normal(rand_comp(), rand_comp(), rand_comp(), 1'($urandom_range(0, 1)));
      if ((k % 40) > 25 && $urandom_range(0, 2) == 0)
        idle_input($urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    guard = 0;
    while (frames.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 20) @(posedge clk);

    if (frames.errors == 0 && frames.pending.size() == 0 && hold_done)
      $display("** tangent_frame_from_normal: PASSED **");
    else
      $display("** tangent_frame_from_normal: FAILED **");
    $finish;
  end
endmodule
